[design/vfsp_pkg.sv]
`timescale 1ns / 1ps
// Package of the video frame sync pacer: types, codes and constants.
// Depends on nothing; every other file of the block imports it.
package vfsp_pkg;

    localparam int TIME_W   = 40;
    localparam int SERIAL_W = 16;
    localparam int DUR_W    = 28;
    localparam int SHORT_W  = 24;
    localparam int RATE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int RATE_FRAC  = 8;
    localparam int DIVIDEND_W = DUR_W + RATE_FRAC;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DUR_W-1:0]   DUR_RESET       = 28'd40000;
    localparam logic [SHORT_W-1:0] MIN_DELAY_RESET = 24'd10000;
    localparam logic [DUR_W-1:0]   MAX_DELAY_RESET = 28'd10000000;
    localparam logic [SHORT_W-1:0] SYNC_RESET      = 24'd100000;
    localparam logic [SHORT_W-1:0] DROP_RESET      = 24'd100000;
    localparam logic [RATE_W-1:0]  RATE_ONE        = 16'd256;
    localparam logic [RATE_W-1:0]  RATE_TOL        = 16'd3;

    // Actions reported for each event.
    typedef enum logic [2:0] {
        ACT_SHOW   = 3'd0,
        ACT_DROP   = 3'd1,
        ACT_STALE  = 3'd2,
        ACT_HELD   = 3'd3,
        ACT_REPEAT = 3'd4,
        ACT_IDLE   = 3'd5
    } action_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DELAY = 3'd0,
        REG_MAX_DELAY = 3'd1,
        REG_SYNC      = 3'd2,
        REG_DROP      = 3'd3,
        REG_RATE      = 3'd4,
        REG_SERIAL    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SHORT_W-1:0]  min_delay_us;
        logic [DUR_W-1:0]    max_delay_us;
        logic [SHORT_W-1:0]  sync_threshold_us;
        logic [SHORT_W-1:0]  drop_threshold_us;
        logic [RATE_W-1:0]   playback_rate_q8;
        logic [SERIAL_W-1:0] current_serial;
    } cfg_t;

endpackage

[design/vfsp_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the video frame sync pacer: events in, results out
// and configuration writes. Depends on vfsp_pkg.
interface vfsp_in_if;
    import vfsp_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [TIME_W-1:0]   frame_pts_us;
    logic [SERIAL_W-1:0] frame_serial;
    logic [TIME_W-1:0]   master_clock_us;
    modport source (output valid, func, frame_pts_us, frame_serial, master_clock_us,
                    input ready);
    modport sink (input valid, func, frame_pts_us, frame_serial, master_clock_us,
                  output ready);
endinterface

interface vfsp_out_if;
    import vfsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [TIME_W-1:0] shown_pts_us;
    logic [TIME_W-1:0] delay_us;
    modport source (output valid, action, shown_pts_us, delay_us, input ready);
    modport sink (input valid, action, shown_pts_us, delay_us, output ready);
endinterface

interface vfsp_cfg_if;
    import vfsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/vfsp_cfg.sv]
`timescale 1ns / 1ps
// Configuration register bank of the video frame sync pacer.
// Depends on vfsp_pkg and vfsp_cfg_if.
module vfsp_cfg (
    input  logic              clk,
    input  logic              rst_n,
    vfsp_cfg_if.sink          cfg,
    output vfsp_pkg::cfg_t    regs
);
    import vfsp_pkg::*;

    cfg_t regs_reg;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    // Register writes; each field keeps only its own width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_delay_us      <= MIN_DELAY_RESET;
            regs_reg.max_delay_us      <= MAX_DELAY_RESET;
            regs_reg.sync_threshold_us <= SYNC_RESET;
            regs_reg.drop_threshold_us <= DROP_RESET;
            regs_reg.playback_rate_q8  <= RATE_ONE;
            regs_reg.current_serial    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_DELAY: regs_reg.min_delay_us      <= cfg.data[SHORT_W-1:0];
                REG_MAX_DELAY: regs_reg.max_delay_us      <= cfg.data[DUR_W-1:0];
                REG_SYNC:      regs_reg.sync_threshold_us <= cfg.data[SHORT_W-1:0];
                REG_DROP:      regs_reg.drop_threshold_us <= cfg.data[SHORT_W-1:0];
                REG_RATE:      regs_reg.playback_rate_q8  <= cfg.data[RATE_W-1:0];
                REG_SERIAL:    regs_reg.current_serial    <= cfg.data[SERIAL_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

[design/vfsp_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on vfsp_pkg.
module vfsp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [vfsp_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [vfsp_pkg::RATE_W-1:0]       divisor,
    output logic                              done,
    output logic [vfsp_pkg::DIVIDEND_W-1:0]   quotient
);
    import vfsp_pkg::*;

    logic [RATE_W-1:0]     rem_reg;
    logic [RATE_W-1:0]     dvs_reg;
    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [RATE_W:0]       trial;
    logic                  fits;

    // Trial subtraction of the next dividend bit.
    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = shift_reg;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            dvs_reg   <= divisor;
            shift_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg   <= fits ? RATE_W'(trial - {1'b0, dvs_reg}) : trial[RATE_W-1:0];
            shift_reg <= {shift_reg[DIVIDEND_W-2:0], fits};
        end
    end

endmodule

[design/video_frame_sync_pacer_unit.sv]
`timescale 1ns / 1ps
// Top level of the video frame sync pacer: event sequencer and state.
// Depends on vfsp_pkg, vfsp_if, vfsp_cfg and vfsp_div.
//
// Channel     Direction  Transfer when       Payload
// frame_in    in         valid && ready      func, frame_pts_us, frame_serial, master_clock_us
// result_out  out        valid && ready      action, shown_pts_us, delay_us
// cfg         in         valid && ready      index, data
//
// Stale, drop, held, repeat and idle results are registered straight from S_DECIDE.
// A shown frame goes on through S_DUR, S_DELAY and S_CLAMP to S_FIN, by way of the
// 36-step bit-serial divider in S_DIV when the playback rate needs it.
// One event is worked on at a time; a finished result waits in the output
// register, so the next event is taken while it is still pending.
// Reset is asynchronous and active low and restores all but the working registers.
module video_frame_sync_pacer_unit (
    input  logic       clk,
    input  logic       rst_n,
    vfsp_in_if.sink    frame_in,
    vfsp_out_if.source result_out,
    vfsp_cfg_if.sink   cfg
);
    import vfsp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_DUR    = 7'b0000100,
        S_DELAY  = 7'b0001000,
        S_CLAMP  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    cfg_t     regs;
    logic     div_start;
    logic     div_done;
    logic [DIVIDEND_W-1:0] quotient;

    state_t state_reg, state_next;

    logic                func_reg;
    logic [TIME_W-1:0]   pts_reg;
    logic [TIME_W-1:0]   master_reg;
    logic [SERIAL_W-1:0] serial_reg;

    logic [TIME_W-1:0] last_pts_reg;
    logic [DUR_W-1:0]  last_dur_reg;
    logic              has_shown_reg;
    logic              held_valid_reg;
    logic [TIME_W-1:0] held_pts_reg;
    logic [TIME_W-1:0] held_master_reg;

    logic [DUR_W-1:0]      dur_reg;
    logic signed [TIME_W:0] diff_reg;
    logic signed [DUR_W+1:0] raw_reg;
    logic [DIVIDEND_W-1:0] res_reg;

    logic              out_valid_reg;
    action_t           out_action_reg;
    logic [TIME_W-1:0] out_pts_reg;
    logic [TIME_W-1:0] out_delay_reg;

    logic                   out_free;
    logic signed [TIME_W:0] late;
    logic                   is_late;
    logic signed [TIME_W:0] step;
    logic                   step_bad;
    logic [DUR_W-1:0]       dur_now;
    logic [TIME_W:0]        abs_diff;
    logic [DUR_W-1:0]       win;
    logic signed [DUR_W+1:0] near_sum;
    logic signed [DUR_W+1:0] min_ext;
    logic [DUR_W-1:0]       clamped;
    logic                   need_div;
    logic [DIVIDEND_W-1:0]  fin_val;

    vfsp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    vfsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({clamped, RATE_FRAC'(0)}),
        .divisor  (regs.playback_rate_q8),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_free         = !out_valid_reg || result_out.ready;
    assign frame_in.ready   = state_reg == S_IDLE;
    assign result_out.valid = out_valid_reg;
    assign result_out.action       = out_action_reg;
    assign result_out.shown_pts_us = out_pts_reg;
    assign result_out.delay_us     = out_delay_reg;

    // Lateness of an arriving frame against the drop threshold.
    assign late    = $signed({1'b0, master_reg}) - $signed({1'b0, pts_reg});
    assign is_late = late > $signed({17'b0, regs.drop_threshold_us});

    // Nominal duration from the last shown time stamp.
    assign step     = $signed({1'b0, pts_reg}) - $signed({1'b0, last_pts_reg});
    assign step_bad = step <= 0 || step > $signed({13'b0, regs.max_delay_us});
    assign dur_now  = step_bad ? last_dur_reg : step[DUR_W-1:0];

    // Correction window against the clock difference.
    assign abs_diff = diff_reg[TIME_W] ? (TIME_W+1)'(-diff_reg) : diff_reg;
    assign win = (dur_reg > DUR_W'(regs.sync_threshold_us)) ? dur_reg
                                                            : DUR_W'(regs.sync_threshold_us);

    // Corrected duration inside the window; the difference fits there.
    assign min_ext  = $signed({6'b0, regs.min_delay_us});
    assign near_sum = $signed({2'b0, dur_reg}) + $signed(diff_reg[DUR_W+1:0]);

    // Clamp to the delay limits; below the minimum the lower one wins.
    always_comb
    begin
        if (raw_reg < $signed({6'b0, regs.min_delay_us}))
            clamped = DUR_W'(regs.min_delay_us);
        else if (raw_reg > $signed({2'b0, regs.max_delay_us}))
            clamped = regs.max_delay_us;
        else
            clamped = raw_reg[DUR_W-1:0];
    end

    // Rate scaling is skipped at zero and within the tolerance around one.
    assign need_div = regs.playback_rate_q8 != '0
                   && (regs.playback_rate_q8 + RATE_TOL <= RATE_ONE
                       || regs.playback_rate_q8 >= RATE_ONE + RATE_TOL);

    // A scaled delay is held at the minimum again.
    assign fin_val = (need_div && res_reg < DIVIDEND_W'(regs.min_delay_us))
                   ? DIVIDEND_W'(regs.min_delay_us) : res_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (frame_in.valid)
                    state_next = S_DECIDE;
            S_DECIDE:
                if (func_reg)
                begin
                    if (held_valid_reg)
                        state_next = S_DUR;
                    else if (out_free)
                        state_next = S_IDLE;
                end
                else if (serial_reg != regs.current_serial || is_late)
                begin
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                    state_next = S_DUR;
            S_DUR:
                state_next = S_DELAY;
            S_DELAY:
                state_next = S_CLAMP;
            S_CLAMP:
                if (need_div)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_FIN;
            S_DIV:
                if (div_done)
                    state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state, pacing state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            last_pts_reg    <= '0;
            last_dur_reg    <= DUR_RESET;
            has_shown_reg   <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_pts_reg    <= '0;
            held_master_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_DECIDE:
                    if (!func_reg && serial_reg == regs.current_serial && is_late
                        && !held_valid_reg && out_free)
                    begin
                        held_valid_reg  <= 1'b1;
                        held_pts_reg    <= pts_reg;
                        held_master_reg <= master_reg;
                    end
                S_DUR:
                begin
                    last_pts_reg   <= pts_reg;
                    last_dur_reg   <= dur_now;
                    has_shown_reg  <= 1'b1;
                    held_valid_reg <= 1'b0;
                end
                default:
                    ;
            endcase
            if ((state_reg == S_DECIDE && state_next == S_IDLE)
                || (state_reg == S_FIN && out_free))
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the event and the output payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && frame_in.valid)
        begin
            func_reg   <= frame_in.func;
            pts_reg    <= frame_in.frame_pts_us;
            serial_reg <= frame_in.frame_serial;
            master_reg <= frame_in.master_clock_us;
        end
        else if (state_reg == S_DECIDE && func_reg && held_valid_reg)
        begin
            pts_reg    <= held_pts_reg;
            master_reg <= held_master_reg;
        end

        if (state_reg == S_DUR)
        begin
            dur_reg  <= dur_now;
            diff_reg <= $signed({1'b0, pts_reg}) - $signed({1'b0, master_reg});
        end

        if (state_reg == S_DELAY)
        begin
            if (abs_diff < {13'b0, win})
                raw_reg <= (near_sum < min_ext) ? min_ext : near_sum;
            else
                raw_reg <= $signed({2'b0, dur_reg});
        end

        if (state_reg == S_CLAMP)
            res_reg <= DIVIDEND_W'(clamped);
        else if (state_reg == S_DIV && div_done)
            res_reg <= quotient;

        // Results decided straight from the event.
        if (state_reg == S_DECIDE && state_next == S_IDLE)
        begin
            out_pts_reg   <= (func_reg && has_shown_reg) ? last_pts_reg : '0;
            out_delay_reg <= '0;
            if (func_reg)
                out_action_reg <= has_shown_reg ? ACT_REPEAT : ACT_IDLE;
            else if (serial_reg != regs.current_serial)
                out_action_reg <= ACT_STALE;
            else
                out_action_reg <= held_valid_reg ? ACT_DROP : ACT_HELD;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            out_action_reg <= ACT_SHOW;
            out_pts_reg    <= pts_reg;
            out_delay_reg  <= TIME_W'(fin_val);
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the video frame sync pacer: directed table, then random traffic
// with both sides idling. Depends on vfsp_pkg, vfsp_if and video_frame_sync_pacer_unit.
module tb;
    import vfsp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        action_t           act;
        logic [TIME_W-1:0] pts;
        logic [TIME_W-1:0] delay;
    } pacer_result_t;

    typedef struct {
        logic                func;
        logic [TIME_W-1:0]   pts;
        logic [SERIAL_W-1:0] serial;
        logic [TIME_W-1:0]   master;
        bit                  typed;
        action_t             act;
        logic [TIME_W-1:0]   exp_pts;
        logic [TIME_W-1:0]   exp_delay;
    } event_row_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    int   snd_idle_pct;
    int   rcv_stall_pct;

    vfsp_in_if  frame_in ();
    vfsp_out_if result_out ();
    vfsp_cfg_if cfg ();

    video_frame_sync_pacer_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in.sink),
        .result_out (result_out.source),
        .cfg        (cfg.sink)
    );

    // Shadow copy of the registers and the display state.
    logic [SHORT_W-1:0]  min_delay;
    logic [DUR_W-1:0]    max_delay;
    logic [SHORT_W-1:0]  sync_thr;
    logic [SHORT_W-1:0]  drop_thr;
    logic [RATE_W-1:0]   rate_q8;
    logic [SERIAL_W-1:0] seek_serial;
    logic [TIME_W-1:0]   last_pts;
    logic [DUR_W-1:0]    last_dur;
    bit                  shown_any;
    bit                  holding;
    logic [TIME_W-1:0]   held_pts;
    logic [TIME_W-1:0]   held_master;

    pacer_result_t pending_results[$];

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Shows a frame: works out its delay and moves the display state on.
    function automatic pacer_result_t present_frame(logic [TIME_W-1:0] pts,
                                                    logic [TIME_W-1:0] mst);
        pacer_result_t r;
        longint dur;
        longint diff;
        longint win;
        longint mag;
        longint d;
        longint q;
        longint off;
        dur = longint'(pts) - longint'(last_pts);
        if (dur <= 0 || dur > longint'(max_delay))
            dur = longint'(last_dur);
        diff = longint'(pts) - longint'(mst);
        win = dur > longint'(sync_thr) ? dur : longint'(sync_thr);
        mag = diff < 0 ? -diff : diff;
        d = dur;
        if (mag < win)
        begin
            d = dur + diff;
            if (d < longint'(min_delay))
                d = longint'(min_delay);
        end
        // Below the minimum the lower clamp wins, otherwise the upper one applies.
        if (d < longint'(min_delay))
            d = longint'(min_delay);
        else if (d > longint'(max_delay))
            d = longint'(max_delay);
        q = longint'(rate_q8);
        off = q - 256;
        if (off < 0)
            off = -off;
        if (q > 0 && off >= 3)
        begin
            d = (d * 256) / q;
            if (d < longint'(min_delay))
                d = longint'(min_delay);
        end
        if (d < 0)
            d = 0;
        if (d > longint'(40'hFF_FFFF_FFFF))
            d = longint'(40'hFF_FFFF_FFFF);
        r.act = ACT_SHOW;
        r.pts = pts;
        r.delay = d[TIME_W-1:0];
        last_pts = pts;
        last_dur = dur[DUR_W-1:0];
        shown_any = 1'b1;
        holding = 1'b0;
        return r;
    endfunction

    function automatic pacer_result_t pacer_predict(logic f, logic [TIME_W-1:0] pts,
                                                    logic [SERIAL_W-1:0] ser,
                                                    logic [TIME_W-1:0] mst);
        pacer_result_t r;
        r.act = ACT_IDLE;
        r.pts = '0;
        r.delay = '0;
        if (f)
        begin
            if (holding)
                r = present_frame(held_pts, held_master);
            else if (shown_any)
            begin
                r.act = ACT_REPEAT;
                r.pts = last_pts;
            end
        end
        else if (ser != seek_serial)
            r.act = ACT_STALE;
        else if (longint'(mst) - longint'(pts) > longint'(drop_thr))
        begin
            if (holding)
                r.act = ACT_DROP;
            else
            begin
                holding = 1'b1;
                held_pts = pts;
                held_master = mst;
                r.act = ACT_HELD;
            end
        end
        else
            r = present_frame(pts, mst);
        return r;
    endfunction

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result transfer at cycle %0d", cycles);
                errors++;
            end
            else
            begin
                if (result_out.action !== pending_results[0].act)
                    report_mismatch("action", TIME_W'(result_out.action),
                                    TIME_W'(pending_results[0].act));
                if (result_out.shown_pts_us !== pending_results[0].pts)
                    report_mismatch("shown_pts_us", result_out.shown_pts_us,
                                    pending_results[0].pts);
                if (result_out.delay_us !== pending_results[0].delay)
                    report_mismatch("delay_us", result_out.delay_us, pending_results[0].delay);
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver stalls.
    always @(negedge clk)
    begin
        result_out.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    task automatic send_event(input logic f, input logic [TIME_W-1:0] pts,
                              input logic [SERIAL_W-1:0] ser, input logic [TIME_W-1:0] mst,
                              input bit typed, input pacer_result_t want);
        pacer_result_t r;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            frame_in.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        frame_in.valid = 1'b1;
        frame_in.func = f;
        frame_in.frame_pts_us = pts;
        frame_in.frame_serial = ser;
        frame_in.master_clock_us = mst;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        r = pacer_predict(f, pts, ser, mst);
        pending_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        frame_in.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_MIN_DELAY: min_delay = value[SHORT_W-1:0];
            REG_MAX_DELAY: max_delay = value[DUR_W-1:0];
            REG_SYNC:      sync_thr = value[SHORT_W-1:0];
            REG_DROP:      drop_thr = value[SHORT_W-1:0];
            REG_RATE:      rate_q8 = value[RATE_W-1:0];
            REG_SERIAL:    seek_serial = value[SERIAL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] mn, input logic [CFG_DATA_W-1:0] mx,
                             input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] dr,
                             input logic [CFG_DATA_W-1:0] rt, input logic [CFG_DATA_W-1:0] sr);
        write_reg(REG_MIN_DELAY, mn);
        write_reg(REG_MAX_DELAY, mx);
        write_reg(REG_SYNC, sy);
        write_reg(REG_DROP, dr);
        write_reg(REG_RATE, rt);
        write_reg(REG_SERIAL, sr);
    endtask

    function automatic logic [TIME_W-1:0] any_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Mostly a steady stream of frames near the master clock, with late bursts,
    // seek leftovers, dry queues and some noise.
    task automatic random_phase(input int count, input bit pause_once);
        logic [TIME_W-1:0]   stream_pts;
        logic [TIME_W-1:0]   pts;
        logic [TIME_W-1:0]   mst;
        logic [SERIAL_W-1:0] ser;
        pacer_result_t       none;
        int                  pick;
        int                  jit;
        none = '{ACT_IDLE, '0, '0};
        stream_pts = {8'd0, $urandom};
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            ser = ($urandom_range(0, 9) == 0) ? SERIAL_W'($urandom) : seek_serial;
            stream_pts = stream_pts + $urandom_range(8000, 45000);
            pts = stream_pts;
            jit = $urandom_range(0, 99);
            if (jit < 75)
                mst = pts + $urandom_range(0, 40000) - 20000;
            else if (jit < 92)
                mst = pts + drop_thr + $urandom_range(1, 200000);
            else
                mst = pts - $urandom_range(0, 3000000);
            if (pick < 8)
                send_event(1'($urandom), any_time(), SERIAL_W'($urandom), any_time(), 1'b0,
                           none);
            else if (pick < 22)
                send_event(1'b1, any_time(), SERIAL_W'($urandom), mst, 1'b0, none);
            else
                send_event(1'b0, pts, ser, mst, 1'b0, none);
            if (pause_once && i == count / 2)
                drain_results();
        end
        drain_results();
    endtask

    event_row_t directed_rows[20];

    initial
    begin
        pacer_result_t want;
        directed_rows = '{
            '{1'b1, 40'd0, 16'd0, 40'd0, 1'b1, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'd5, 16'd1, 40'd5, 1'b1, ACT_STALE, 40'd0, 40'd0},
            '{1'b0, 40'd1000000, 16'd0, 40'd1000000, 1'b1, ACT_SHOW, 40'd1000000, 40'd1000000},
            '{1'b1, 40'd0, 16'd0, 40'd1000000, 1'b1, ACT_REPEAT, 40'd1000000, 40'd0},
            '{1'b0, 40'd2000000, 16'd0, 40'd3000000, 1'b1, ACT_HELD, 40'd0, 40'd0},
            '{1'b0, 40'd2040000, 16'd0, 40'd3000000, 1'b1, ACT_DROP, 40'd0, 40'd0},
            '{1'b0, 40'd2050000, 16'd7, 40'd3000000, 1'b1, ACT_STALE, 40'd0, 40'd0},
            // Queue dry releases the held frame with its stored master clock.
            '{1'b1, 40'd0, 16'd0, 40'd0, 1'b1, ACT_SHOW, 40'd2000000, 40'd1000000},
            '{1'b0, 40'd2100000, 16'd0, 40'd2500000, 1'b1, ACT_HELD, 40'd0, 40'd0},
            // A timely frame ends the episode and discards the held one.
            '{1'b0, 40'd2140000, 16'd0, 40'd2140000, 1'b1, ACT_SHOW, 40'd2140000, 40'd140000},
            '{1'b1, 40'd0, 16'd0, 40'd0, 1'b1, ACT_REPEAT, 40'd2140000, 40'd0},
            '{1'b0, 40'd0, 16'd0, 40'd0, 1'b0, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'hFF_FFFF_FFFF, 16'd0, 40'hFF_FFFF_FFFF, 1'b0, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'hFF_FFFF_FFFF, 16'd0, 40'd0, 1'b0, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'd0, 16'd0, 40'hFF_FFFF_FFFF, 1'b1, ACT_HELD, 40'd0, 40'd0},
            '{1'b1, 40'hFF_FFFF_FFFF, 16'hFFFF, 40'd0, 1'b0, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'd100, 16'hFFFF, 40'd50, 1'b1, ACT_STALE, 40'd0, 40'd0},
            // Lateness equal to the threshold is still timely.
            '{1'b0, 40'd1000000, 16'd0, 40'd1100000, 1'b0, ACT_IDLE, 40'd0, 40'd0},
            '{1'b0, 40'd1000000, 16'd0, 40'd1100001, 1'b1, ACT_HELD, 40'd0, 40'd0},
            '{1'b1, 40'd0, 16'd0, 40'd0, 1'b0, ACT_IDLE, 40'd0, 40'd0}
        };
        cycles = 0;
        errors = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        rst_n = 1'b0;
        frame_in.valid = 1'b0;
        frame_in.func = 1'b0;
        frame_in.frame_pts_us = '0;
        frame_in.frame_serial = '0;
        frame_in.master_clock_us = '0;
        result_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_MIN_DELAY;
        cfg.data = '0;
        min_delay = MIN_DELAY_RESET;
        max_delay = MAX_DELAY_RESET;
        sync_thr = SYNC_RESET;
        drop_thr = DROP_RESET;
        rate_q8 = RATE_ONE;
        seek_serial = '0;
        last_pts = '0;
        last_dur = DUR_RESET;
        shown_any = 1'b0;
        holding = 1'b0;
        held_pts = '0;
        held_master = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the reset configuration.
        foreach (directed_rows[i])
        begin
            want = '{directed_rows[i].act, directed_rows[i].exp_pts, directed_rows[i].exp_delay};
            send_event(directed_rows[i].func, directed_rows[i].pts, directed_rows[i].serial,
                       directed_rows[i].master, directed_rows[i].typed, want);
        end
        drain_results();

        // Random phases under changing register settings and idling patterns.
        random_phase(300, 1'b0);
        write_all(28'd5000, 28'd200000, 28'd30000, 28'd60000, 28'd128, 28'($urandom));
        snd_idle_pct = 61;
        random_phase(350, 1'b0);
        write_all(28'd20000, 28'd5000000, 28'd80000, 28'd150000, 28'd512, 28'($urandom));
        snd_idle_pct = 0;
        rcv_stall_pct = 61;
        random_phase(350, 1'b1);
        // Minimum above maximum, zero thresholds and zero rate.
        write_all(28'hFFF_FFFF, 28'd0, 28'd0, 28'd0, 28'd0, 28'hFFF_FFFF);
        snd_idle_pct = 18;
        rcv_stall_pct = 18;
        random_phase(300, 1'b0);
        // Widest limits and the fastest rate.
        write_all(28'd0, 28'hFFF_FFFF, 28'hFF_FFFF, 28'hFF_FFFF, 28'hFFFF, 28'($urandom));
        snd_idle_pct = 40;
        rcv_stall_pct = 30;
        random_phase(300, 1'b0);
        // Rate just outside the tolerance, then just inside it.
        write_all(28'd10000, 28'd10000000, 28'd100000, 28'd100000, 28'd259, 28'($urandom));
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        random_phase(200, 1'b0);
        write_reg(REG_RATE, 28'd254);
        random_phase(200, 1'b0);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
